[hdl/ultrasonic_range_controller_unit_assert.svh]
// ---------------------------------------------------------------------------
// urc assertion macros
// shared concurrent assertion forms, clocked on i_clk, held off in reset
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_CONTROLLER_UNIT_ASSERT_SVH
`define ULTRASONIC_RANGE_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define URC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("urc assertion failed");

// next-cycle implication
`define URC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("urc assertion failed");

`endif

[hdl/urc_pkg.sv]
// ---------------------------------------------------------------------------
// urc_pkg
// types, codes and constants shared by the range controller modules
// ---------------------------------------------------------------------------
package urc_pkg;

    // stream and config port widths
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 20;

    // register widths
    localparam int unsigned LOW_W  = 16;
    localparam int unsigned HIGH_W = 16;
    localparam int unsigned HOLD_W = 20;
    localparam int unsigned DIST_W = 10;
    localparam int unsigned DIG_W  = 4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_TICKS    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_TICKS   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_TICKS   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DISTANCE = 2'd3;

    // register reset values
    localparam logic [LOW_W-1:0]  RST_LOW_TICKS    = 16'd3;
    localparam logic [HIGH_W-1:0] RST_HIGH_TICKS   = 16'd2;
    localparam logic [HOLD_W-1:0] RST_HOLD_TICKS   = 20'd50001;
    localparam logic [DIST_W-1:0] RST_MAX_DISTANCE = 10'd999;

    // arithmetic: every echo count at or above ECHO_CLAMP maps past the
    // display limit, so the datapath only ever sees 13 bit counts
    localparam int unsigned TC_W       = 13;
    localparam int unsigned ECHO_CLAMP = 6000;
    localparam int unsigned X_W        = 17;   // 17*6000 and 102*1021 fit
    localparam int unsigned Q_W        = 11;
    localparam int unsigned RECIP_W    = 11;
    localparam int unsigned REM_W      = 7;
    localparam logic [RECIP_W-1:0] RECIP_100 = 11'd1310;  // floor(2^17/100)
    localparam logic [X_W-1:0] MUL_SOUND = 17'd17;
    localparam logic [X_W-1:0] MUL_TEMP  = 17'd102;
    localparam logic [X_W-1:0] DIV_BASE  = 17'd100;
    localparam logic [DIST_W-1:0] DIST_LIMIT = 10'd999;

    // tick phases
    typedef enum logic [4:0] {
        PH_LOW     = 5'b00001,
        PH_PULSE   = 5'b00010,
        PH_WAIT    = 5'b00100,
        PH_MEASURE = 5'b01000,
        PH_HOLD    = 5'b10000
    } t_phase;

    // conversion sequencer
    typedef enum logic [9:0] {
        SEQ_IDLE    = 10'b0000000001,
        SEQ_RECIP_A = 10'b0000000010,
        SEQ_CORR_A  = 10'b0000000100,
        SEQ_SCALE   = 10'b0000001000,
        SEQ_RECIP_B = 10'b0000010000,
        SEQ_CORR_B  = 10'b0000100000,
        SEQ_CLAMP   = 10'b0001000000,
        SEQ_RECIP_C = 10'b0010000000,
        SEQ_CORR_C  = 10'b0100000000,
        SEQ_PUBLISH = 10'b1000000000
    } t_seq;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_RECIP  = 3'd2,
        OP_CORR   = 3'd3,
        OP_SCALE  = 3'd4,
        OP_CLAMP  = 3'd5,
        OP_DIGITS = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        DSEL_LOW  = 2'd0,
        DSEL_HIGH = 2'd1,
        DSEL_HOLD = 2'd2
    } t_delay_sel;

    typedef struct packed {
        logic       count_en;
        t_delay_sel delay_sel;
        logic       echo_start;
        logic       echo_inc;
        t_op        op;
        logic       out_load;
        logic       out_trig;
        logic       out_done;
    } t_dp_cmd;

    typedef struct packed {
        logic low_done;
        logic high_done;
        logic hold_done;
    } t_dp_status;

    // tens digit of a value below 100
    function automatic logic [DIG_W-1:0] tens_of(input logic [REM_W-1:0] v);
        logic [DIG_W-1:0] c;
        c = '0;
        for (int i = 1; i <= 9; i++) begin
            if (v >= REM_W'(10 * i)) begin
                c = c + 1'b1;
            end
        end
        return c;
    endfunction

endpackage

[hdl/ultrasonic_range_controller_unit.sv]
// ---------------------------------------------------------------------------
// ultrasonic_range_controller_unit
// ranging sequencer: trigger pulse, echo timing, distance and digit output
// ---------------------------------------------------------------------------
//
//  channel      | signals                              | moves
//  -------------+--------------------------------------+--------------------------
//  tick in      | i_s_axis_tvalid/tready/tdata         | one echo sample per tick
//  result out   | o_m_axis_tvalid/tready/tdata/tuser   | one result per tick
//  config       | i_cfg_we/addr/wdata                  | register write, no wait
//
//  the tick on which echo falls goes on into the conversion sequencer,
//  which runs three divide by 100 passes (reciprocal multiply then
//  correction) through one shared unit
//  the input is taken while an earlier result still sits in the output
//  register, as long as that register frees up in the same cycle
//  a stall on the result side holds the output register and blocks input
//  synchronous active low reset: phase to trigger low, counters and shown
//  distance to zero, registers to their defaults; no clearing pass
//
module ultrasonic_range_controller_unit #(
    parameter int unsigned ECHO_COUNT_BITS  = 16,
    parameter int unsigned DELAY_COUNT_BITS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tick in
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [urc_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,   // [0] echo_level, rest zero
    // result out
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [urc_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,   // [0] trigger_level,
                                                                  // [10:1] distance_cm,
                                                                  // [14:11] digit_hundreds,
                                                                  // [18:15] digit_tens,
                                                                  // [22:19] digit_ones, [23] zero
    output logic                                o_m_axis_tuser,   // [0] reading_done
    // config
    input  logic                                i_cfg_we,
    input  logic [urc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [urc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import urc_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // phase machine and conversion sequencer
    urc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_echo    (i_s_axis_tdata[0]),
        .i_m_ready (i_m_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid)
    );

    // counters, divide unit, shown reading and output payload
    urc_dp #(
        .ECHO_COUNT_BITS  (ECHO_COUNT_BITS),
        .DELAY_COUNT_BITS (DELAY_COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

endmodule

[hdl/urc_ctrl.sv]
// ---------------------------------------------------------------------------
// urc_ctrl
// tick phase machine, conversion sequencer and output valid
// ---------------------------------------------------------------------------
`include "ultrasonic_range_controller_unit_assert.svh"

module urc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_valid,
    input  logic                 i_echo,
    input  logic                 i_m_ready,
    input  urc_pkg::t_dp_status  i_status,
    output urc_pkg::t_dp_cmd     o_cmd,
    output logic                 o_s_ready,
    output logic                 o_m_valid
);
    import urc_pkg::*;

    t_phase   r_phase, n_phase;
    t_seq     r_seq, n_seq;
    logic     r_out_valid, n_out_valid;
    logic     w_slot_free;
    logic     w_accept;
    t_dp_cmd  w_cmd;

    assign w_slot_free = !r_out_valid || i_m_ready;
    assign o_s_ready   = (r_seq == SEQ_IDLE) && w_slot_free;
    assign w_accept    = i_s_valid && o_s_ready;

    always_comb begin
        w_cmd   = '0;
        n_phase = r_phase;
        n_seq   = r_seq;
        case (r_seq)
            SEQ_IDLE: begin
                if (w_accept) begin
                    w_cmd.out_load = 1'b1;
                    case (r_phase)
                        PH_PULSE: begin
                            w_cmd.out_trig  = 1'b1;
                            w_cmd.count_en  = 1'b1;
                            w_cmd.delay_sel = DSEL_HIGH;
                            if (i_status.high_done) begin
                                n_phase = PH_WAIT;
                            end
                        end
                        PH_WAIT: begin
                            if (i_echo) begin
                                w_cmd.echo_start = 1'b1;
                                n_phase          = PH_MEASURE;
                            end
                        end
                        PH_MEASURE: begin
                            if (i_echo) begin
                                w_cmd.echo_inc = 1'b1;
                            end else begin
                                // echo fell: result waits for the conversion
                                w_cmd.op       = OP_LOAD;
                                w_cmd.out_load = 1'b0;
                                n_phase        = PH_HOLD;
                                n_seq          = SEQ_RECIP_A;
                            end
                        end
                        PH_HOLD: begin
                            w_cmd.count_en  = 1'b1;
                            w_cmd.delay_sel = DSEL_HOLD;
                            if (i_status.hold_done) begin
                                n_phase = PH_LOW;
                            end
                        end
                        default: begin
                            w_cmd.count_en  = 1'b1;
                            w_cmd.delay_sel = DSEL_LOW;
                            n_phase = i_status.low_done ? PH_PULSE : PH_LOW;
                        end
                    endcase
                end
            end
            SEQ_RECIP_A: begin
                w_cmd.op = OP_RECIP;
                n_seq    = SEQ_CORR_A;
            end
            SEQ_CORR_A: begin
                w_cmd.op = OP_CORR;
                n_seq    = SEQ_SCALE;
            end
            SEQ_SCALE: begin
                w_cmd.op = OP_SCALE;
                n_seq    = SEQ_RECIP_B;
            end
            SEQ_RECIP_B: begin
                w_cmd.op = OP_RECIP;
                n_seq    = SEQ_CORR_B;
            end
            SEQ_CORR_B: begin
                w_cmd.op = OP_CORR;
                n_seq    = SEQ_CLAMP;
            end
            SEQ_CLAMP: begin
                w_cmd.op = OP_CLAMP;
                n_seq    = SEQ_RECIP_C;
            end
            SEQ_RECIP_C: begin
                w_cmd.op = OP_RECIP;
                n_seq    = SEQ_CORR_C;
            end
            SEQ_CORR_C: begin
                w_cmd.op = OP_CORR;
                n_seq    = SEQ_PUBLISH;
            end
            SEQ_PUBLISH: begin
                if (w_slot_free) begin
                    w_cmd.op       = OP_DIGITS;
                    w_cmd.out_load = 1'b1;
                    w_cmd.out_done = 1'b1;
                    n_seq          = SEQ_IDLE;
                end
            end
            default: begin
                n_seq = SEQ_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LOW;
            r_seq       <= SEQ_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd     = w_cmd;
    assign o_m_valid = r_out_valid;

    `URC_ASSERT_NXT(a_echo_end_starts_conv, w_accept && (r_phase == PH_MEASURE) && !i_echo, (r_seq == SEQ_RECIP_A) && (r_phase == PH_HOLD))
    `URC_ASSERT_NXT(a_publish_gives_result, (r_seq == SEQ_PUBLISH) && w_slot_free, r_out_valid && (r_seq == SEQ_IDLE))
    `URC_ASSERT_IMP(a_no_accept_in_conv, r_seq != SEQ_IDLE, !w_accept && !w_cmd.count_en)

endmodule

[hdl/urc_dp.sv]
// ---------------------------------------------------------------------------
// urc_dp
// config registers, tick counters, distance conversion and output register
// ---------------------------------------------------------------------------
`include "ultrasonic_range_controller_unit_assert.svh"

module urc_dp #(
    parameter int unsigned ECHO_COUNT_BITS  = 16,
    parameter int unsigned DELAY_COUNT_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [urc_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [urc_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  urc_pkg::t_dp_cmd                      i_cmd,
    output urc_pkg::t_dp_status                   o_status,
    output logic [urc_pkg::OUT_TDATA_W-1:0]       o_out_data,
    output logic                                  o_out_user
);
    import urc_pkg::*;

    localparam int unsigned CW = (DELAY_COUNT_BITS > HOLD_W) ? DELAY_COUNT_BITS : HOLD_W;
    localparam int unsigned TW = (ECHO_COUNT_BITS > TC_W) ? ECHO_COUNT_BITS : TC_W;
    localparam int unsigned PROD_W = X_W + RECIP_W;
    localparam logic [DELAY_COUNT_BITS-1:0] DMAX = '1;
    localparam logic [ECHO_COUNT_BITS-1:0]  EMAX = '1;

    // config
    logic [LOW_W-1:0]  r_low_ticks;
    logic [HIGH_W-1:0] r_high_ticks;
    logic [HOLD_W-1:0] r_hold_ticks;
    logic [DIST_W-1:0] r_max_dist;

    // counters
    logic [DELAY_COUNT_BITS-1:0] r_tick;
    logic [ECHO_COUNT_BITS-1:0]  r_echo;
    logic [DELAY_COUNT_BITS-1:0] w_cnt_inc;
    logic [CW-1:0]               w_cnt_ext;
    logic                        w_cnt_max;
    logic                        w_sel_done;

    // conversion
    logic [X_W-1:0]    r_x;
    logic [Q_W-1:0]    r_q;
    logic [REM_W-1:0]  r_rem;
    logic [TW-1:0]     w_t_ext;
    logic [TC_W-1:0]   w_tc;
    logic [PROD_W-1:0] w_prod;
    logic [X_W-1:0]    w_r;
    logic              w_r_hi;
    logic [DIST_W-1:0] w_lim;
    logic [DIST_W-1:0] w_d;

    // shown reading
    logic [DIST_W-1:0] r_dist;
    logic [DIG_W-1:0]  r_hund, n_hund;
    logic [DIG_W-1:0]  r_tens, n_tens;
    logic [DIG_W-1:0]  r_ones, n_ones;

    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_ticks  <= RST_LOW_TICKS;
            r_high_ticks <= RST_HIGH_TICKS;
            r_hold_ticks <= RST_HOLD_TICKS;
            r_max_dist   <= RST_MAX_DISTANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LOW_TICKS:    r_low_ticks  <= i_cfg_wdata[LOW_W-1:0];
                CFG_HIGH_TICKS:   r_high_ticks <= i_cfg_wdata[HIGH_W-1:0];
                CFG_HOLD_TICKS:   r_hold_ticks <= i_cfg_wdata[HOLD_W-1:0];
                CFG_MAX_DISTANCE: r_max_dist   <= i_cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // delay counter: saturating, a phase ends when the count reaches its length
    assign w_cnt_inc = (r_tick < DMAX) ? r_tick + 1'b1 : r_tick;
    assign w_cnt_ext = CW'(w_cnt_inc);
    assign w_cnt_max = (w_cnt_inc == DMAX);

    assign o_status.low_done  = (w_cnt_ext >= CW'(r_low_ticks))  || w_cnt_max;
    assign o_status.high_done = (w_cnt_ext >= CW'(r_high_ticks)) || w_cnt_max;
    assign o_status.hold_done = (w_cnt_ext >= CW'(r_hold_ticks)) || w_cnt_max;

    always_comb begin
        case (i_cmd.delay_sel)
            DSEL_HIGH: w_sel_done = o_status.high_done;
            DSEL_HOLD: w_sel_done = o_status.hold_done;
            default:   w_sel_done = o_status.low_done;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (i_cmd.count_en) begin
            r_tick <= w_sel_done ? '0 : w_cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo <= '0;
        end else if (i_cmd.echo_start) begin
            r_echo <= ECHO_COUNT_BITS'(1);
        end else if (i_cmd.echo_inc) begin
            if (r_echo != EMAX) begin
                r_echo <= r_echo + 1'b1;
            end
        end else if (i_cmd.op == OP_LOAD) begin
            r_echo <= '0;
        end
    end

    // counts past the clamp all land beyond the display limit
    assign w_t_ext = TW'(r_echo);
    assign w_tc    = (w_t_ext > TW'(ECHO_CLAMP)) ? TC_W'(ECHO_CLAMP) : w_t_ext[TC_W-1:0];

    // divide by 100: reciprocal estimate, low by at most one, then one correction
    assign w_prod = PROD_W'(r_x) * PROD_W'(RECIP_100);
    assign w_r    = r_x - X_W'(X_W'(r_q) * DIV_BASE);
    assign w_r_hi = (w_r >= DIV_BASE);

    assign w_lim = (r_max_dist > DIST_LIMIT) ? DIST_LIMIT : r_max_dist;
    assign w_d   = (r_q > Q_W'(w_lim)) ? w_lim : r_q[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_x <= X_W'(X_W'(w_tc) * MUL_SOUND);
            end
            OP_RECIP: begin
                r_q <= w_prod[PROD_W-1 -: Q_W];
            end
            OP_CORR: begin
                if (w_r_hi) begin
                    r_q   <= r_q + 1'b1;
                    r_rem <= REM_W'(w_r - DIV_BASE);
                end else begin
                    r_rem <= REM_W'(w_r);
                end
            end
            OP_SCALE: begin
                r_x <= X_W'((X_W'(r_q) + 1'b1) * MUL_TEMP);
            end
            OP_CLAMP: begin
                r_x <= X_W'(w_d);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_hund = r_hund;
        n_tens = r_tens;
        n_ones = r_ones;
        if (i_cmd.op == OP_DIGITS) begin
            n_hund = r_q[DIG_W-1:0];
            n_tens = tens_of(r_rem);
            n_ones = DIG_W'(r_rem - REM_W'(REM_W'(n_tens) * REM_W'(10)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= '0;
            r_hund <= '0;
            r_tens <= '0;
            r_ones <= '0;
        end else begin
            if (i_cmd.op == OP_CLAMP) begin
                r_dist <= w_d;
            end
            r_hund <= n_hund;
            r_tens <= n_tens;
            r_ones <= n_ones;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {1'b0, n_ones, n_tens, n_hund, r_dist, i_cmd.out_trig};
            r_out_user <= i_cmd.out_done;
        end
    end

    assign o_out_data = r_out_data;
    assign o_out_user = r_out_user;

    `URC_ASSERT_NXT(a_rem_below_base, i_cmd.op == OP_CORR, r_rem < REM_W'(100))
    `URC_ASSERT_NXT(a_dist_in_range, i_cmd.op == OP_CLAMP, r_dist <= DIST_LIMIT)
    `URC_ASSERT_NXT(a_delay_restarts, i_cmd.count_en && w_sel_done, r_tick == '0)

endmodule
